// ----- src/gps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the glide phase-step oscillator.
package gps_pkg;

  localparam int unsigned GPS_ADDR_W    = 5;
  localparam int unsigned GPS_DATA_W    = 32;
  localparam int unsigned GPS_STEP_W    = 32;
  localparam int unsigned GPS_LEN_W     = 20;
  localparam int unsigned GPS_DEPTH_W   = 16;
  localparam int unsigned GPS_MOD_W     = 16;
  localparam int unsigned GPS_DIV_STEPS = 32;
  localparam int unsigned GPS_FRAC_SH   = 27;

  localparam logic [GPS_STEP_W:0]     GPS_ONE_TURN   = {1'b1, {GPS_STEP_W{1'b0}}};
  localparam logic [GPS_STEP_W-1:0]   GPS_STEP_MAX   = '1;
  localparam logic [GPS_STEP_W-1:0]   GPS_FACTOR_ONE = GPS_STEP_W'(1) << GPS_FRAC_SH;

  typedef enum logic [2:0] {
    REG_STEP_SCALE       = 3'd0,
    REG_GLIDE_SAMPLES    = 3'd1,
    REG_RESPONSE_SAMPLES = 3'd2,
    REG_MOD1_DEPTH       = 3'd3,
    REG_MOD2_DEPTH       = 3'd4
  } gps_reg_e;

  typedef struct packed {
    logic [GPS_STEP_W-1:0]  step_scale;
    logic [GPS_LEN_W-1:0]   glide_samples;
    logic [GPS_LEN_W-1:0]   response_samples;
    logic [GPS_DEPTH_W-1:0] mod1_depth;
    logic [GPS_DEPTH_W-1:0] mod2_depth;
  } gps_cfg_t;

endpackage

// ----- src/gps_regs.sv -----
`timescale 1ns / 1ps
// APB configuration registers of the oscillator.
module gps_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gps_pkg::GPS_ADDR_W-1:0]    paddr,
  input  logic [gps_pkg::GPS_DATA_W-1:0]    pwdata,
  output logic [gps_pkg::GPS_DATA_W-1:0]    prdata,
  output logic                              pready,
  output gps_pkg::gps_cfg_t                 cfg_o
);
  import gps_pkg::*;

  gps_cfg_t cfg_q;
  gps_reg_e reg_idx;
  logic     wr_en;

  assign reg_idx = gps_reg_e'(paddr[GPS_ADDR_W-1:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_STEP_SCALE:       cfg_q.step_scale       <= pwdata;
        REG_GLIDE_SAMPLES:    cfg_q.glide_samples    <= pwdata[GPS_LEN_W-1:0];
        REG_RESPONSE_SAMPLES: cfg_q.response_samples <= pwdata[GPS_LEN_W-1:0];
        REG_MOD1_DEPTH:       cfg_q.mod1_depth       <= pwdata[GPS_DEPTH_W-1:0];
        REG_MOD2_DEPTH:       cfg_q.mod2_depth       <= pwdata[GPS_DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STEP_SCALE:       prdata = cfg_q.step_scale;
      REG_GLIDE_SAMPLES:    prdata = GPS_DATA_W'(cfg_q.glide_samples);
      REG_RESPONSE_SAMPLES: prdata = GPS_DATA_W'(cfg_q.response_samples);
      REG_MOD1_DEPTH:       prdata = GPS_DATA_W'(cfg_q.mod1_depth);
      REG_MOD2_DEPTH:       prdata = GPS_DATA_W'(cfg_q.mod2_depth);
      default:              prdata = '0;
    endcase
  end

endmodule

// ----- src/gps_div.sv -----
`timescale 1ns / 1ps
// Radix-2 restoring divider, 32 quotient bits, one bit per cycle.
module gps_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [gps_pkg::GPS_STEP_W-1:0]    dividend_hi_i,
  input  logic [gps_pkg::GPS_STEP_W-1:0]    dividend_lo_i,
  input  logic [gps_pkg::GPS_STEP_W-1:0]    divisor_i,
  output logic                              done_o,
  output logic [gps_pkg::GPS_STEP_W-1:0]    quotient_o
);
  import gps_pkg::*;

  localparam int unsigned CNT_W = $clog2(GPS_DIV_STEPS);

  logic                  busy_q, done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [GPS_STEP_W-1:0] rem_q, quo_q, dvs_q;
  logic [GPS_STEP_W:0]   trial, diff;
  logic                  ge;

  // caller guarantees dividend_hi < divisor, so the quotient fits 32 bits
  assign trial = {rem_q, quo_q[GPS_STEP_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(GPS_DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_hi_i;
      quo_q <= dividend_lo_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[GPS_STEP_W-1:0] : trial[GPS_STEP_W-1:0];
      quo_q <= {quo_q[GPS_STEP_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q) else $error("done without a running divide");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < dvs_q) else $error("partial remainder not below divisor");
`endif

endmodule

// ----- src/glide_phase_step_oscillator.sv -----
`timescale 1ns / 1ps
// Top level: sequencer, shared multiplier, glide and phase state of the oscillator.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | input     | in_valid_i / in_stall_o | frequency, note_on, note_slide, playing,
//          |           |                        | mod_one, mod_two
//  out     | output    | out_valid_o/out_stall_i | cycle_trigger, base_step, final_step
//  cfg     | input     | psel/penable/pready    | 5 registers at byte address 4*i
//
// Per sample: target multiply, glide decision, a glide divide when a glide starts, and
// per nonzero modulation depth a factor multiply then a step multiply, or a divide for a
// negative modulation; divides use the shared radix-2 divider, multiplies the shared
// 32x32 multiplier. A new sample is taken only when the sequencer is idle.
// Reset clears the step, glide and phase state (phase starts at one full turn).
// A stalled result is held in the output registers; the next sample may be accepted
// meanwhile and waits in its final cycle until the output is free.
module glide_phase_step_oscillator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gps_pkg::GPS_ADDR_W-1:0]    paddr,
  input  logic [gps_pkg::GPS_DATA_W-1:0]    pwdata,
  output logic [gps_pkg::GPS_DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [31:0]                       frequency_i,
  input  logic                              note_on_i,
  input  logic                              note_slide_i,
  input  logic                              playing_i,
  input  logic signed [gps_pkg::GPS_MOD_W-1:0] mod_one_i,
  input  logic signed [gps_pkg::GPS_MOD_W-1:0] mod_two_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              cycle_trigger_o,
  output logic [gps_pkg::GPS_STEP_W-1:0]    base_step_o,
  output logic [gps_pkg::GPS_STEP_W-1:0]    final_step_o
);
  import gps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_TGT, S_DECIDE, S_GDIV, S_APPLY,
    S_MFACT, S_MADD, S_MMUL, S_MSAT, S_MDIV, S_PHASE
  } state_e;

  gps_cfg_t cfg;

  gps_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e state_q;

  // captured sample
  logic [31:0]           freq_q;
  logic                  note_on_q, note_slide_q, playing_q;
  logic [GPS_MOD_W-1:0]  mod_one_q, mod_two_q;

  // oscillator state
  logic [GPS_STEP_W-1:0] base_q;
  logic [GPS_STEP_W:0]   inc_q;
  logic [GPS_LEN_W-1:0]  remain_q;
  logic [GPS_STEP_W:0]   phase_q;
  logic                  trig_q;

  // working registers
  logic [2*GPS_STEP_W-1:0] prod_q;
  logic [GPS_STEP_W-1:0]   cur_q, factor_q;
  logic                    neg_q, mod_sel_q, glide_neg_q;

  logic                    out_valid_q;
  logic [GPS_STEP_W-1:0]   out_base_q, out_final_q;

  // shared multiplier operands
  logic [GPS_STEP_W-1:0] mul_a, mul_b;
  logic                  mul_en;

  // divider hookup
  logic                  div_start, div_done;
  logic [GPS_STEP_W-1:0] div_hi, div_lo, div_dvs, div_quo;

  logic [GPS_STEP_W-1:0]  target, up_diff, down_diff, factor_sum, sat_step;
  logic                   target_below, do_glide, do_jump;
  logic [GPS_LEN_W-1:0]   glide_len;
  logic [GPS_DEPTH_W-1:0] depth;
  logic [GPS_MOD_W-1:0]   mval, mmag;
  logic [GPS_STEP_W+1:0]  next_base;
  logic [GPS_STEP_W:0]    phase_sum;
  logic [2*GPS_STEP_W-GPS_FRAC_SH-1:0] scaled;
  logic                   wrap, out_free;

  assign target       = prod_q[2*GPS_STEP_W-1:GPS_STEP_W];
  assign up_diff      = target - base_q;
  assign down_diff    = base_q - target;
  assign target_below = target < base_q;

  always_comb begin
    do_glide  = 1'b0;
    do_jump   = 1'b0;
    glide_len = cfg.glide_samples;
    if (note_slide_q) begin
      if (cfg.glide_samples == '0) do_jump = 1'b1;
      else                         do_glide = 1'b1;
    end else if (note_on_q) begin
      glide_len = cfg.response_samples;
      if (base_q == '0 || cfg.response_samples == '0 || !playing_q) do_jump = 1'b1;
      else                                                         do_glide = 1'b1;
    end
  end

  assign depth = mod_sel_q ? cfg.mod2_depth : cfg.mod1_depth;
  assign mval  = mod_sel_q ? mod_two_q : mod_one_q;
  assign mmag  = mval[GPS_MOD_W-1] ? (GPS_MOD_W'(0) - mval) : mval;

  assign factor_sum = GPS_FACTOR_ONE + prod_q[GPS_STEP_W-1:0];

  assign scaled   = prod_q[2*GPS_STEP_W-1:GPS_FRAC_SH];
  assign sat_step = (scaled[2*GPS_STEP_W-GPS_FRAC_SH-1:GPS_STEP_W] != '0) ?
                    GPS_STEP_MAX : scaled[GPS_STEP_W-1:0];

  // signed add of the increment, clamped to the step range
  assign next_base = {2'b00, base_q} + {inc_q[GPS_STEP_W], inc_q};

  // phase stays at or below one turn, so the sum fits 33 bits
  assign phase_sum = phase_q + {1'b0, cur_q};
  assign wrap      = phase_sum[GPS_STEP_W] && (phase_sum[GPS_STEP_W-1:0] != '0);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = freq_q;
    mul_b  = cfg.step_scale;
    case (state_q)
      S_TGT: mul_en = 1'b1;
      S_MFACT: begin
        mul_en = 1'b1;
        mul_a  = GPS_STEP_W'(depth);
        mul_b  = GPS_STEP_W'(mmag);
      end
      S_MMUL: begin
        mul_en = 1'b1;
        mul_a  = cur_q;
        mul_b  = factor_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= (2*GPS_STEP_W)'(mul_a) * (2*GPS_STEP_W)'(mul_b);
  end

  always_comb begin
    div_start = 1'b0;
    div_hi    = '0;
    div_lo    = target_below ? down_diff : up_diff;
    div_dvs   = GPS_STEP_W'(glide_len);
    case (state_q)
      S_DECIDE: div_start = do_glide;
      S_MADD: begin
        // dividend is the step shifted left by the factor's fraction bits
        div_start = neg_q;
        div_hi    = {{(GPS_STEP_W-GPS_FRAC_SH){1'b0}},
                     cur_q[GPS_STEP_W-1:GPS_STEP_W-GPS_FRAC_SH]};
        div_lo    = {cur_q[GPS_STEP_W-GPS_FRAC_SH-1:0], {GPS_FRAC_SH{1'b0}}};
        div_dvs   = factor_sum;
      end
      default: ;
    endcase
  end

  gps_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (div_start),
    .dividend_hi_i (div_hi),
    .dividend_lo_i (div_lo),
    .divisor_i     (div_dvs),
    .done_o        (div_done),
    .quotient_o    (div_quo)
  );

  // sample capture and data-path working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          freq_q       <= frequency_i;
          note_on_q    <= note_on_i;
          note_slide_q <= note_slide_i;
          playing_q    <= playing_i;
          mod_one_q    <= mod_one_i;
          mod_two_q    <= mod_two_i;
        end
      end
      S_DECIDE: glide_neg_q <= target_below;
      S_APPLY: begin
        if (remain_q != '0) begin
          if (next_base[GPS_STEP_W+1])   cur_q <= '0;
          else if (next_base[GPS_STEP_W]) cur_q <= GPS_STEP_MAX;
          else                           cur_q <= next_base[GPS_STEP_W-1:0];
        end else begin
          cur_q <= base_q;
        end
      end
      S_MFACT: neg_q <= mval[GPS_MOD_W-1];
      S_MADD:  factor_q <= factor_sum;
      S_MSAT:  cur_q <= sat_step;
      S_MDIV:  if (div_done) cur_q <= div_quo;
      S_PHASE: begin
        if (out_free) begin
          out_base_q  <= base_q;
          out_final_q <= cur_q;
        end
      end
      default: ;
    endcase
  end

  // sequencer and oscillator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      inc_q       <= '0;
      remain_q    <= '0;
      phase_q     <= GPS_ONE_TURN;
      trig_q      <= 1'b0;
      mod_sel_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_PHASE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE:   if (in_valid_i) state_q <= S_TGT;
        S_TGT:    state_q <= S_DECIDE;
        S_DECIDE: begin
          if (do_jump) begin
            base_q   <= target;
            inc_q    <= '0;
            remain_q <= '0;
            state_q  <= S_APPLY;
          end else if (do_glide) begin
            remain_q <= glide_len;
            state_q  <= S_GDIV;
          end else begin
            state_q  <= S_APPLY;
          end
        end
        S_GDIV: begin
          if (div_done) begin
            inc_q   <= glide_neg_q ? ((GPS_STEP_W+1)'(0) - {1'b0, div_quo})
                                   : {1'b0, div_quo};
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (remain_q != '0) begin
            if (next_base[GPS_STEP_W+1])    base_q <= '0;
            else if (next_base[GPS_STEP_W]) base_q <= GPS_STEP_MAX;
            else                            base_q <= next_base[GPS_STEP_W-1:0];
            remain_q <= remain_q - GPS_LEN_W'(1);
          end
          mod_sel_q <= 1'b0;
          state_q   <= S_MFACT;
        end
        S_MFACT: begin
          if (depth != '0) begin
            state_q <= S_MADD;
          end else if (!mod_sel_q) begin
            mod_sel_q <= 1'b1;
          end else begin
            state_q <= S_PHASE;
          end
        end
        S_MADD: state_q <= neg_q ? S_MDIV : S_MMUL;
        S_MMUL: state_q <= S_MSAT;
        S_MSAT, S_MDIV: begin
          if (state_q == S_MSAT || div_done) begin
            if (!mod_sel_q) begin
              mod_sel_q <= 1'b1;
              state_q   <= S_MFACT;
            end else begin
              state_q   <= S_PHASE;
            end
          end
        end
        S_PHASE: begin
          if (out_free) begin
            phase_q     <= wrap ? {1'b0, phase_sum[GPS_STEP_W-1:0]} : phase_sum;
            trig_q      <= wrap;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign cycle_trigger_o = trig_q;
  assign base_step_o     = out_base_q;
  assign final_step_o    = out_final_q;

`ifndef SYNTHESIS
  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !phase_q[GPS_STEP_W] || (phase_q[GPS_STEP_W-1:0] == '0))
    else $error("phase above one turn");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_TGT)
    else $error("accepted transaction did not start the sequencer");
  a_result_from_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_PHASE))
    else $error("result raised outside the final step");
  a_div_idle_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == S_GDIV || state_q == S_MDIV))
    else $error("divide started without waiting for it");
`endif

endmodule

// ----- tb/sv/glide_phase_step_checker.sv -----
`timescale 1ns / 1ps
// Checker for the glide phase-step oscillator: tracks register writes, predicts, compares.
module glide_phase_step_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [gps_pkg::GPS_ADDR_W-1:0] paddr,
  input  logic [gps_pkg::GPS_DATA_W-1:0] pwdata,
  input  logic                           in_valid_i,
  input  logic                           in_stall_o,
  input  logic [31:0]                    frequency_i,
  input  logic                           note_on_i,
  input  logic                           note_slide_i,
  input  logic                           playing_i,
  input  logic [15:0]                    mod_one_i,
  input  logic [15:0]                    mod_two_i,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  logic                           cycle_trigger_o,
  input  logic [31:0]                    base_step_o,
  input  logic [31:0]                    final_step_o,
  output int                             fail_count,
  output int                             pending_count,
  output int                             checked_count,
  output int                             wrap_count
);

  localparam logic [32:0] FULL_TURN = 33'h1_0000_0000;
  localparam longint      STEP_CEIL = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic        trigger;
    logic [31:0] base_step;
    logic [31:0] final_step;
  } step_result_t;

  step_result_t step_results_q[$];

  // register copies
  logic [31:0] scale_r;
  logic [19:0] glide_len_r;
  logic [19:0] resp_len_r;
  logic [15:0] depth1_r;
  logic [15:0] depth2_r;

  // oscillator state
  logic [31:0] base_r;
  longint      glide_inc;
  logic [19:0] glide_left;
  logic [32:0] phase_r;

  // One modulation stage: multiply by (1 + depth*m/2^27), or divide by (1 + depth*|m|/2^27) for m < 0.
  function automatic logic [31:0] apply_mod(logic [31:0] step, logic [15:0] depth,
                                            logic signed [15:0] m);
    logic signed [16:0] m_w;
    logic [63:0]        mag;
    logic [63:0]        factor;
    logic [63:0]        prod;
    if (depth == '0) return step;
    m_w = m;
    if (m_w < 0) m_w = -m_w;
    mag    = {47'd0, m_w};
    factor = (64'd1 << 27) + {48'd0, depth} * mag;
    if (m < 0) return 32'(({32'd0, step} << 27) / factor);
    prod = ({32'd0, step} * factor) >> 27;
    return (prod > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  task automatic advance_oscillator(input logic [31:0] freq, input logic on,
                                    input logic slide, input logic play,
                                    input logic [15:0] m1, input logic [15:0] m2);
    logic [63:0]  prod;
    logic [31:0]  target;
    logic [31:0]  s1;
    logic [19:0]  len;
    logic         do_jump;
    logic         do_glide;
    longint       diff;
    longint       nb;
    step_result_t r;
    prod     = {32'd0, freq} * {32'd0, scale_r};
    target   = prod[63:32];
    do_jump  = 1'b0;
    do_glide = 1'b0;
    len      = '0;
    if (slide) begin
      if (glide_len_r == '0) do_jump = 1'b1;
      else begin
        do_glide = 1'b1;
        len      = glide_len_r;
      end
    end else if (on) begin
      if (base_r == '0 || resp_len_r == '0 || !play) do_jump = 1'b1;
      else begin
        do_glide = 1'b1;
        len      = resp_len_r;
      end
    end
    if (do_jump) begin
      base_r     = target;
      glide_left = '0;
      glide_inc  = 0;
    end
    if (do_glide) begin
      diff       = longint'({32'd0, target}) - longint'({32'd0, base_r});
      glide_inc  = diff / longint'({44'd0, len});
      glide_left = len;
    end
    // first glide increment lands on the same sample
    if (glide_left != '0) begin
      nb = longint'({32'd0, base_r}) + glide_inc;
      if (nb < 0) nb = 0;
      if (nb > STEP_CEIL) nb = STEP_CEIL;
      base_r     = nb[31:0];
      glide_left = glide_left - 20'd1;
    end
    s1           = apply_mod(base_r, depth1_r, m1);
    r.final_step = apply_mod(s1, depth2_r, m2);
    r.base_step  = base_r;
    phase_r      = phase_r + {1'b0, r.final_step};
    // wrap only when strictly past one turn
    if (phase_r > FULL_TURN) begin
      phase_r   = phase_r - FULL_TURN;
      r.trigger = 1'b1;
    end else begin
      r.trigger = 1'b0;
    end
    step_results_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    step_result_t want;
    if (!rst_ni) begin
      scale_r       = '0;
      glide_len_r   = '0;
      resp_len_r    = '0;
      depth1_r      = '0;
      depth2_r      = '0;
      base_r        = '0;
      glide_inc     = 0;
      glide_left    = '0;
      phase_r       = FULL_TURN;
      step_results_q.delete();
      fail_count    = 0;
      pending_count = 0;
      checked_count = 0;
      wrap_count    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          gps_pkg::REG_STEP_SCALE:       scale_r     = pwdata;
          gps_pkg::REG_GLIDE_SAMPLES:    glide_len_r = pwdata[19:0];
          gps_pkg::REG_RESPONSE_SAMPLES: resp_len_r  = pwdata[19:0];
          gps_pkg::REG_MOD1_DEPTH:       depth1_r    = pwdata[15:0];
          gps_pkg::REG_MOD2_DEPTH:       depth2_r    = pwdata[15:0];
          default: ;
        endcase
      end
      // compare before taking a new sample, so a stray result is never masked
      if (out_valid_o && !out_stall_i) begin
        if (step_results_q.size() == 0) begin
          $error("result transaction with no sample pending");
          fail_count++;
        end else begin
          want = step_results_q.pop_front();
          if (cycle_trigger_o !== want.trigger) begin
            $error("cycle_trigger: expected %0d, got %0d", want.trigger, cycle_trigger_o);
            fail_count++;
          end
          if (base_step_o !== want.base_step) begin
            $error("base_step: expected %h, got %h", want.base_step, base_step_o);
            fail_count++;
          end
          if (final_step_o !== want.final_step) begin
            $error("final_step: expected %h, got %h", want.final_step, final_step_o);
            fail_count++;
          end
          if (cycle_trigger_o === 1'b1) wrap_count++;
          checked_count++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        advance_oscillator(frequency_i, note_on_i, note_slide_i, playing_i,
                           mod_one_i, mod_two_i);
      end
      pending_count = step_results_q.size();
    end
  end

endmodule

// ----- tb/sv/glide_phase_step_oscillator_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the glide phase-step oscillator: stimulus, flow control and verdict.
module glide_phase_step_oscillator_tb;

  localparam logic [2:0] UNUSED_REG_IDX = 3'd7;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HOLD} stall_mode_e;

  typedef struct packed {
    logic [31:0] freq;
    logic        note_on;
    logic        note_slide;
    logic        playing;
    logic [15:0] mod_one;
    logic [15:0] mod_two;
  } sample_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [gps_pkg::GPS_ADDR_W-1:0] paddr;
  logic [gps_pkg::GPS_DATA_W-1:0] pwdata;
  logic [gps_pkg::GPS_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [31:0]                    frequency_i;
  logic                           note_on_i;
  logic                           note_slide_i;
  logic                           playing_i;
  logic signed [15:0]             mod_one_i;
  logic signed [15:0]             mod_two_i;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic                           cycle_trigger_o;
  logic [31:0]                    base_step_o;
  logic [31:0]                    final_step_o;

  int fail_count;
  int pending_count;
  int checked_count;
  int wrap_count;

  int          samples_sent;
  int          settings_used;
  int          burst_left;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_span = 0;

  glide_phase_step_oscillator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .frequency_i     (frequency_i),
    .note_on_i       (note_on_i),
    .note_slide_i    (note_slide_i),
    .playing_i       (playing_i),
    .mod_one_i       (mod_one_i),
    .mod_two_i       (mod_two_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cycle_trigger_o (cycle_trigger_o),
    .base_step_o     (base_step_o),
    .final_step_o    (final_step_o)
  );

  glide_phase_step_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .frequency_i     (frequency_i),
    .note_on_i       (note_on_i),
    .note_slide_i    (note_slide_i),
    .playing_i       (playing_i),
    .mod_one_i       (mod_one_i),
    .mod_two_i       (mod_two_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cycle_trigger_o (cycle_trigger_o),
    .base_step_o     (base_step_o),
    .final_step_o    (final_step_o),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .checked_count   (checked_count),
    .wrap_count      (wrap_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver: alternates between free flow, random stalls and solid holds
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      stall_span = (stall_mode == STALL_HOLD) ? $urandom_range(1, 24) : $urandom_range(10, 150);
    end
    stall_span--;
    case (stall_mode)
      STALL_NONE:   out_stall_i <= 1'b0;
      STALL_RANDOM: out_stall_i <= ($urandom_range(0, 9) < 4);
      default:      out_stall_i <= 1'b1;
    endcase
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_settings(input logic [31:0] scale, input logic [19:0] glide,
                                input logic [19:0] resp, input logic [15:0] d1,
                                input logic [15:0] d2);
    cfg_write(gps_pkg::REG_STEP_SCALE, scale);
    cfg_write(gps_pkg::REG_GLIDE_SAMPLES, {12'd0, glide});
    cfg_write(gps_pkg::REG_RESPONSE_SAMPLES, {12'd0, resp});
    cfg_write(gps_pkg::REG_MOD1_DEPTH, {16'd0, d1});
    cfg_write(gps_pkg::REG_MOD2_DEPTH, {16'd0, d2});
    settings_used++;
  endtask

  // valid stays up inside a burst; a gap follows when the burst runs out
  task automatic send_sample(input sample_t s);
    in_valid_i   <= 1'b1;
    frequency_i  <= s.freq;
    note_on_i    <= s.note_on;
    note_slide_i <= s.note_slide;
    playing_i    <= s.playing;
    mod_one_i    <= s.mod_one;
    mod_two_i    <= s.mod_two;
    do @(posedge clk_i); while (in_stall_o);
    samples_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 20);
    end
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending_count == 0);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic sample_t mk_sample(input logic [31:0] f, input logic on,
                                        input logic slide, input logic play,
                                        input logic [15:0] m1, input logic [15:0] m2);
    sample_t s;
    s.freq       = f;
    s.note_on    = on;
    s.note_slide = slide;
    s.playing    = play;
    s.mod_one    = m1;
    s.mod_two    = m2;
    return s;
  endfunction

  function automatic logic [15:0] random_mod();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'h0000;
      3:       return 16'h7FFF;
      4:       return 16'h8000;
      5, 6:    return 16'($urandom_range(0, 4000)) - 16'd2000;
      default: return 16'($urandom());
    endcase
  endfunction

  // mostly plain notes, with occasional note-ons and slides to start glides
  function automatic sample_t random_sample();
    sample_t s;
    case ($urandom_range(0, 9))
      0:       s.freq = 32'h0000_0000;
      1:       s.freq = 32'hFFFF_FFFF;
      2, 3:    s.freq = $urandom_range(32'h0000_1000, 32'h00FF_FFFF);
      default: s.freq = $urandom();
    endcase
    s.note_slide = ($urandom_range(0, 7) == 0);
    s.note_on    = ($urandom_range(0, 4) == 0);
    s.playing    = ($urandom_range(0, 4) != 0);
    s.mod_one    = random_mod();
    s.mod_two    = random_mod();
    return s;
  endfunction

  function automatic logic [19:0] pick_length(input int sel, input int k);
    case (sel % 4)
      0:       return 20'd0;
      1:       return 20'd1;
      2:       return 20'($urandom_range(2, 40));
      default: return (k == 3) ? 20'hFFFFF : 20'($urandom_range(2, 40));
    endcase
  endfunction

  function automatic logic [15:0] pick_depth(input int sel);
    case (sel % 4)
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 4096));
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    frequency_i  = '0;
    note_on_i    = 1'b0;
    note_slide_i = 1'b0;
    playing_i    = 1'b0;
    mod_one_i    = '0;
    mod_two_i    = '0;
    samples_sent  = 0;
    settings_used = 0;
    burst_left    = $urandom_range(1, 20);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values written back explicitly; a write past the last register is ignored
    apply_settings(32'h0, 20'd0, 20'd0, 16'h0, 16'h0);
    cfg_write(UNUSED_REG_IDX, 32'hFFFF_FFFF);
    repeat (3) send_sample(random_sample());
    drain();

    // full-scale step scale: target is frequency minus one for a nonzero frequency
    apply_settings(32'hFFFF_FFFF, 20'd4, 20'd3, 16'hFFFF, 16'h1000);
    send_sample(mk_sample(32'h0000_0000, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000));
    // note-on from a zero step jumps; half-turn steps land exactly on one turn
    send_sample(mk_sample(32'h8000_0001, 1'b1, 1'b0, 1'b1, 16'h0000, 16'h0000));
    send_sample(mk_sample(32'h8000_0001, 1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000));
    send_sample(mk_sample(32'h8000_0001, 1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000));
    // note-on while playing glides down, slide wins over a simultaneous note-on
    send_sample(mk_sample(32'h2000_0000, 1'b1, 1'b0, 1'b1, 16'h0000, 16'h0000));
    send_sample(mk_sample(32'h2000_0000, 1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000));
    send_sample(mk_sample(32'hFFFF_0000, 1'b1, 1'b1, 1'b1, 16'h0000, 16'h0000));
    // note-on while not playing jumps and cancels the glide
    send_sample(mk_sample(32'h1000_0000, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000));
    send_sample(mk_sample(32'h0000_0000, 1'b0, 1'b0, 1'b1, 16'h7FFF, 16'h0000));
    send_sample(mk_sample(32'h0000_0000, 1'b0, 1'b0, 1'b1, 16'h8000, 16'h0000));
    send_sample(mk_sample(32'h0000_0000, 1'b0, 1'b0, 1'b1, 16'h7FFF, 16'h7FFF));
    send_sample(mk_sample(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 16'h7FFF, 16'h7FFF));
    send_sample(mk_sample(32'h0000_0000, 1'b0, 1'b0, 1'b1, 16'hFFFF, 16'h8000));
    send_sample(mk_sample(32'h0000_0000, 1'b0, 1'b0, 1'b1, 16'h0001, 16'hFFFF));
    send_sample(mk_sample(32'h0000_0000, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000));
    send_sample(mk_sample(32'h0000_0000, 1'b0, 1'b0, 1'b1, 16'h7FFF, 16'h8000));
    send_sample(mk_sample(32'h4000_0000, 1'b1, 1'b0, 1'b1, 16'h0000, 16'h0000));
    drain();

    // zero glide and response lengths: every trigger jumps
    apply_settings(32'h8000_0000, 20'd0, 20'd0, 16'hFFFF, 16'hFFFF);
    send_sample(mk_sample(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 16'h0000, 16'h0000));
    send_sample(mk_sample(32'h1234_5678, 1'b1, 1'b0, 1'b1, 16'h0000, 16'h0000));
    send_sample(mk_sample(32'hFFFF_0000, 1'b0, 1'b1, 1'b1, 16'h0000, 16'h0000));
    send_sample(mk_sample(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 16'h7FFF, 16'h7FFF));
    send_sample(mk_sample(32'h0000_0001, 1'b1, 1'b1, 1'b0, 16'h8000, 16'h8000));
    send_sample(mk_sample(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 16'h8000, 16'h7FFF));
    drain();

    for (int k = 0; k < 8; k++) begin
      apply_settings((k == 0) ? 32'hFFFF_FFFF : $urandom(), pick_length(k, k),
                     pick_length(k + 1, k), pick_depth(k), pick_depth(k + 2));
      repeat (60) send_sample(random_sample());
      drain();
    end

    repeat (150) @(posedge clk_i);
    $display("tb: %0d samples over %0d register settings, %0d results checked",
             samples_sent, settings_used, checked_count);
    $display("tb: %0d phase wraps seen, glides and modulation extremes included", wrap_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
